// File: src/lbps_pkg.sv
// Shared constants, types and pattern ROM of the LED and buzzer pattern sequencer.
package lbps_pkg;

    localparam int TICK_MS = 10;
    localparam int STEPS   = 6;
    localparam int STATES  = 9;

    localparam int COLS    = 8;
    localparam int STW     = 4;
    localparam int STEPW   = 3;
    localparam int TICKW   = 12;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [TICKW-1:0] T50   = TICKW'(50 / TICK_MS);
    localparam logic [TICKW-1:0] T100  = TICKW'(100 / TICK_MS);
    localparam logic [TICKW-1:0] T500  = TICKW'(500 / TICK_MS);
    localparam logic [TICKW-1:0] T750  = TICKW'(750 / TICK_MS);
    localparam logic [TICKW-1:0] T1000 = TICKW'(1000 / TICK_MS);
    localparam logic [TICKW-1:0] T1500 = TICKW'(1500 / TICK_MS);
    localparam logic [TICKW-1:0] T2000 = TICKW'(2000 / TICK_MS);
    localparam logic [TICKW-1:0] T3000 = TICKW'(3000 / TICK_MS);

    typedef struct packed {
        logic [COLS-1:0]            valid;
        logic [COLS-1:0][TICKW-1:0] ticks;
        logic [COLS-1:0]            lvl;
        logic                       rep;
    } t_row;

    typedef struct packed {
        logic level;
        logic running;
    } t_chan_out;

    function automatic t_row mk_row(input int n,
                                    input logic [TICKW-1:0] a0, input logic [TICKW-1:0] a1,
                                    input logic [TICKW-1:0] a2, input logic [TICKW-1:0] a3,
                                    input logic [TICKW-1:0] a4, input logic [TICKW-1:0] a5,
                                    input logic [7:0] lvl, input logic rep);
        t_row r;
        r = '0;
        r.ticks[0] = a0;
        r.ticks[1] = a1;
        r.ticks[2] = a2;
        r.ticks[3] = a3;
        r.ticks[4] = a4;
        r.ticks[5] = a5;
        for (int i = 0; i < COLS; i++) begin
            r.valid[i] = (i < n) && (i < STEPS);
        end
        r.lvl = lvl;
        r.rep = rep;
        return r;
    endfunction

    function automatic logic known_state(input logic [STW-1:0] st);
        return ({1'b0, st} < 5'(STATES)) && (st < 4'd9);
    endfunction

    function automatic t_row led_row(input logic [STW-1:0] st);
        t_row r;
        case (st)
            4'd0:    r = mk_row(4, T100, T50, T100, T1000, '0, '0, 8'h05, 1'b1);
            4'd1:    r = mk_row(2, T3000, T3000, '0, '0, '0, '0, 8'h01, 1'b1);
            4'd2:    r = mk_row(2, T500, T500, '0, '0, '0, '0, 8'h01, 1'b1);
            4'd3:    r = mk_row(1, T50, '0, '0, '0, '0, '0, 8'h01, 1'b0);
            4'd4:    r = mk_row(6, T100, T50, T100, T500, T500, T2000, 8'h15, 1'b1);
            4'd5:    r = mk_row(2, T100, T1000, '0, '0, '0, '0, 8'h01, 1'b1);
            4'd6:    r = mk_row(6, T500, T500, T500, T500, T1500, T2000, 8'h15, 1'b1);
            4'd7:    r = mk_row(2, T100, T100, '0, '0, '0, '0, 8'h01, 1'b1);
            4'd8:    r = mk_row(2, T100, T3000, '0, '0, '0, '0, 8'h01, 1'b1);
            default: r = '0;
        endcase
        if (!known_state(st)) begin
            r = '0;
        end
        return r;
    endfunction

    function automatic t_row beep_row(input logic [STW-1:0] st);
        t_row r;
        r = mk_row(2, T750, T500, '0, '0, '0, '0, 8'h01, 1'b0);
        if (!known_state(st)) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// File: src/lbps_chan.sv
// One pattern channel: step, tick counter, drive level and run flag.
module lbps_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_tick,
    input  lbps_pkg::t_row      i_row,
    output lbps_pkg::t_chan_out o_next
);
    import lbps_pkg::*;

    logic [STEPW-1:0] r_step, n_step, s_step;
    logic [TICKW-1:0] r_ticks, n_ticks, s_ticks;
    logic             r_level, n_level, s_level;
    logic             r_running, n_running, s_running;
    logic [TICKW-1:0] need;
    logic [TICKW-1:0] inc;
    logic [STEPW:0]   nxt;
    logic             nxt_ok;
    logic [STEPW-1:0] wrap_step;

    always_comb begin
        s_step    = r_step;
        s_ticks   = r_ticks;
        s_level   = r_level;
        s_running = r_running;
        if (i_start) begin
            s_step  = '0;
            s_ticks = '0;
            if (i_row.valid[0]) begin
                s_level   = i_row.lvl[0];
                s_running = 1'b1;
            end else begin
                s_running = 1'b0;
            end
        end

        need      = i_row.valid[s_step] ? i_row.ticks[s_step] : '0;
        inc       = s_ticks + TICKW'(1);
        nxt       = {1'b0, s_step} + (STEPW+1)'(1);
        nxt_ok    = (nxt < (STEPW+1)'(STEPS)) && i_row.valid[nxt[STEPW-1:0]];
        wrap_step = nxt_ok ? nxt[STEPW-1:0] : '0;

        n_step    = s_step;
        n_ticks   = s_ticks;
        n_level   = s_level;
        n_running = s_running;
        if (i_tick && s_running) begin
            n_ticks = inc;
            if (inc > need) begin
                if (!nxt_ok && !i_row.rep) begin
                    n_step    = '0;
                    n_running = 1'b0;
                end else begin
                    n_step  = wrap_step;
                    n_ticks = '0;
                    n_level = i_row.lvl[wrap_step];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_ticks   <= '0;
            r_level   <= 1'b0;
            r_running <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_ticks   <= n_ticks;
            r_level   <= n_level;
            r_running <= n_running;
        end
    end

    assign o_next.level   = n_level;
    assign o_next.running = n_running;

endmodule

// File: src/lbps_out.sv
// Result register of the master-side stream.
module lbps_out (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_data,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_free
);
    logic       r_valid, n_valid;
    logic [7:0] r_data;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/led_buzzer_pattern_sequencer.sv
// Top level of the LED and buzzer pattern sequencer.
// A result word is registered and valid in the cycle after its input word is taken.
// Throughput: one input word per cycle; the result register stalls input
// only while it holds a word that the master side has not taken.
// Reset (synchronous, active low) clears the pending request, the shown
// state, both channels and the valid flag of the result register.
module led_buzzer_pattern_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [3:0] new_state, [7:4] zero
    input  logic       i_s_axis_tuser,  // [0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata   // [0] led_on, [1] buzzer_on, [2] led_active,
                                        // [3] buzzer_active, [7:4] shown_state
);
    import lbps_pkg::*;

    logic           in_acc;
    logic           tick;
    logic           start;
    logic           free;
    logic           r_pending_valid, n_pending_valid;
    logic [STW-1:0] r_pending_state, n_pending_state;
    logic [STW-1:0] r_active_state, n_active_state;
    t_row           led_r, beep_r;
    t_chan_out      led_n, beep_n;

    assign in_acc = i_s_axis_tvalid && free;
    assign tick   = in_acc && (i_s_axis_tuser == KIND_TICK);
    assign start  = tick && r_pending_valid;

    always_comb begin
        n_pending_valid = r_pending_valid;
        n_pending_state = r_pending_state;
        n_active_state  = r_active_state;
        if (in_acc && (i_s_axis_tuser == KIND_REQUEST)) begin
            n_pending_valid = 1'b1;
            n_pending_state = i_s_axis_tdata[STW-1:0];
        end else if (start) begin
            n_pending_valid = 1'b0;
            n_active_state  = r_pending_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_valid <= 1'b0;
            r_pending_state <= '0;
            r_active_state  <= '0;
        end else begin
            r_pending_valid <= n_pending_valid;
            r_pending_state <= n_pending_state;
            r_active_state  <= n_active_state;
        end
    end

    assign led_r  = led_row(n_active_state);
    assign beep_r = beep_row(n_active_state);

    lbps_chan u_led (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_tick  (tick),
        .i_row   (led_r),
        .o_next  (led_n)
    );

    lbps_chan u_beep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_tick  (tick),
        .i_row   (beep_r),
        .o_next  (beep_n)
    );

    lbps_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_data  ({n_active_state, beep_n.running, led_n.running, beep_n.level, led_n.level}),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_free  (free)
    );

    assign o_s_axis_tready = free;

    a_req_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser == KIND_REQUEST) |=> r_pending_valid)
        else $error("request word did not leave a pending state");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_m_axis_tvalid)
        else $error("accepted word produced no result word");

    a_start_applies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (!r_pending_valid && r_active_state == $past(r_pending_state)))
        else $error("pending state not applied on tick");

endmodule
